// ===== rtl/vshp_pkg.sv =====
// Shared types, constants and lookup tables for the sequence header parser.
// No dependencies; imported by every module of the block.
package vshp_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int PREFIX_BYTES = 13;
	localparam int NFIELDS      = 18;
	localparam int FQ_DEPTH     = 4;

	// Grammar steps in bitstream order
	typedef enum logic [4:0] {
		ST_MAJOR    = 5'd0,
		ST_MINOR    = 5'd1,
		ST_PROFILE  = 5'd2,
		ST_LEVEL    = 5'd3,
		ST_FORMAT   = 5'd4,
		ST_SIZE_F   = 5'd5,
		ST_WIDTH    = 5'd6,
		ST_HEIGHT   = 5'd7,
		ST_CHROMA_F = 5'd8,
		ST_CHROMA   = 5'd9,
		ST_SCAN_F   = 5'd10,
		ST_INTERL   = 5'd11,
		ST_TOPFF    = 5'd12,
		ST_RATE_F   = 5'd13,
		ST_RATE_IX  = 5'd14,
		ST_RATE_N   = 5'd15,
		ST_RATE_D   = 5'd16,
		ST_ASP_F    = 5'd17,
		ST_ASP_IX   = 5'd18,
		ST_ASP_N    = 5'd19,
		ST_ASP_D    = 5'd20,
		ST_CLEAN_F  = 5'd21,
		ST_CLEAN_W  = 5'd22,
		ST_CLEAN_H  = 5'd23,
		ST_CLEAN_L  = 5'd24,
		ST_CLEAN_T  = 5'd25,
		ST_DONE     = 5'd26
	} gstep_t;

	typedef enum logic [1:0] {
		C_RUN  = 2'd0,
		C_EMIT = 2'd1,
		C_ERR  = 2'd2
	} cstate_t;

	typedef enum logic [1:0] {
		RES_NONE = 2'd0,
		RES_ALL  = 2'd1,
		RES_ERR  = 2'd2
	} gres_t;

	// Byte as classified by the front end
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       skip;
	} fe_item_t;

	// One result request
	typedef struct packed {
		logic [4:0]  field_code;
		logic [31:0] field_value;
		logic        last_field;
		logic        parse_error;
	} result_t;

	typedef logic [11:0][31:0] fmt_row_t;

	function automatic fmt_row_t mk_row(input logic [31:0] a, b, c, d, e, f,
		input logic [31:0] g, h, i, j, k, l);
		fmt_row_t r;
		r[0] = a; r[1] = b; r[2] = c;  r[3] = d;  r[4] = e;  r[5] = f;
		r[6] = g; r[7] = h; r[8] = i;  r[9] = j;  r[10] = k; r[11] = l;
		return r;
	endfunction

	// Base format defaults; columns land in fields 5,6,8..17
	function automatic fmt_row_t fmt_row(input logic [4:0] fmt);
		fmt_row_t r;
		case (fmt)
			5'd1:  r = mk_row(176, 120, 0, 0, 15000, 1001, 10, 11, 176, 120, 0, 0);
			5'd2:  r = mk_row(176, 144, 0, 1, 25, 2, 12, 11, 176, 144, 0, 0);
			5'd3:  r = mk_row(352, 240, 0, 0, 15000, 1001, 10, 11, 352, 240, 0, 0);
			5'd4:  r = mk_row(352, 288, 0, 1, 25, 2, 12, 11, 352, 288, 0, 0);
			5'd5:  r = mk_row(704, 480, 0, 0, 15000, 1001, 10, 11, 704, 480, 0, 0);
			5'd6:  r = mk_row(704, 576, 0, 1, 25, 2, 12, 11, 704, 576, 0, 0);
			5'd7:  r = mk_row(720, 480, 1, 0, 30000, 1001, 10, 11, 704, 480, 8, 0);
			5'd8:  r = mk_row(720, 576, 1, 1, 25, 1, 12, 11, 704, 576, 8, 0);
			5'd9:  r = mk_row(1280, 720, 0, 1, 60000, 1001, 1, 1, 1280, 720, 0, 0);
			5'd10: r = mk_row(1280, 720, 0, 1, 50, 1, 1, 1, 1280, 720, 0, 0);
			5'd11: r = mk_row(1920, 1080, 1, 1, 30000, 1001, 1, 1, 1920, 1080, 0, 0);
			5'd12: r = mk_row(1920, 1080, 1, 1, 25, 1, 1, 1, 1920, 1080, 0, 0);
			5'd13: r = mk_row(1920, 1080, 0, 1, 60000, 1001, 1, 1, 1920, 1080, 0, 0);
			5'd14: r = mk_row(1920, 1080, 0, 1, 50, 1, 1, 1, 1920, 1080, 0, 0);
			5'd15: r = mk_row(2048, 1080, 0, 1, 24, 1, 1, 1, 2048, 1080, 0, 0);
			5'd16: r = mk_row(4096, 2160, 0, 1, 24, 1, 1, 1, 2048, 1536, 0, 0);
			default: r = mk_row(640, 480, 0, 0, 24000, 1001, 1, 1, 640, 480, 0, 0);
		endcase
		return r;
	endfunction

	// Frame rate presets: {numerator, denominator}
	function automatic logic [63:0] rate_pair(input logic [3:0] ix);
		logic [63:0] r;
		case (ix)
			4'd1:    r = {32'd24000, 32'd1001};
			4'd2:    r = {32'd24, 32'd1};
			4'd3:    r = {32'd25, 32'd1};
			4'd4:    r = {32'd30000, 32'd1001};
			4'd5:    r = {32'd30, 32'd1};
			4'd6:    r = {32'd50, 32'd1};
			4'd7:    r = {32'd60000, 32'd1001};
			4'd8:    r = {32'd60, 32'd1};
			4'd9:    r = {32'd15000, 32'd1001};
			4'd10:   r = {32'd25, 32'd2};
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	// Pixel aspect presets: {numerator, denominator}
	function automatic logic [63:0] aspect_pair(input logic [2:0] ix);
		logic [63:0] r;
		case (ix)
			3'd1:    r = {32'd1, 32'd1};
			3'd2:    r = {32'd10, 32'd11};
			3'd3:    r = {32'd12, 32'd11};
			3'd4:    r = {32'd40, 32'd33};
			3'd5:    r = {32'd16, 32'd11};
			3'd6:    r = {32'd4, 32'd3};
			default: r = 64'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/vshp_front.sv =====
// Front end: takes unit bytes, tags prefix bytes to skip, and queues them.
// Depends on vshp_pkg.
module vshp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  logic              deq,
	output logic              head_valid,
	output vshp_pkg::fe_item_t head
);
	import vshp_pkg::*;

	localparam int PW = $clog2(FQ_DEPTH);

	fe_item_t          mem_q [FQ_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       cnt_q;
	logic [3:0]        prefix_q;
	logic              acc;
	logic              pop_ok;

	assign full       = (cnt_q == (PW+1)'(FQ_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign acc        = push && !full;
	assign pop_ok     = deq && head_valid;

	// Count prefix bytes; restart at each unit end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (acc) begin
			if (last_byte)
				prefix_q <= '0;
			else if (prefix_q < 4'(PREFIX_BYTES))
				prefix_q <= prefix_q + 4'd1;
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (acc) begin
			mem_q[wr_q].data <= data_byte;
			mem_q[wr_q].last <= last_byte;
			mem_q[wr_q].skip <= (prefix_q < 4'(PREFIX_BYTES));
		end
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (acc)
				wr_q <= wr_q + PW'(1);
			if (pop_ok)
				rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(acc) - (PW+1)'(pop_ok);
		end
	end

endmodule

// ===== rtl/vshp_outq.sv =====
// Result queue: two-entry buffer between the decoder and the result port.
// Depends on vshp_pkg.
module vshp_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  vshp_pkg::result_t wr_item,
	output logic              wr_full,
	input  logic              pop,
	output logic              empty,
	output vshp_pkg::result_t rd_item
);
	import vshp_pkg::*;

	result_t    mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       acc, pop_ok;

	assign wr_full = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_item = mem_q[rd_q];
	assign acc     = wr && !wr_full;
	assign pop_ok  = pop && !empty;

	// Hold results
	always_ff @(posedge clk) begin
		if (acc)
			mem_q[wr_q] <= wr_item;
	end

	// Advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (acc)
				wr_q <= ~wr_q;
			if (pop_ok)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(pop_ok);
		end
	end

endmodule

// ===== rtl/vshp_core.sv =====
// Back end: bit-serial code decoder, header grammar and field emitter.
// Depends on vshp_pkg; fed by vshp_front, drains into vshp_outq.
module vshp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  vshp_pkg::fe_item_t head,
	output logic               deq,
	output logic               out_wr,
	output vshp_pkg::result_t  out_item,
	input  logic               out_full
);
	import vshp_pkg::*;

	cstate_t      state_q, state_d;
	gstep_t       step_q, step_d;
	logic [5:0]   pairs_q, pairs_d;
	logic [31:0]  accum_q, accum_d;
	logic         half_q, half_d;
	logic [31:0]  fields_q [NFIELDS];
	logic [31:0]  fields_d [NFIELDS];
	logic [2:0]   bit_q, bit_d;
	logic [4:0]   idx_q, idx_d;
	logic         rearm_q, rearm_d;
	logic         bit_go, b, done, rearm;
	gres_t        res;
	logic [31:0]  v;
	fmt_row_t     row;
	logic [4:0]   fmt;
	logic [63:0]  rp, ap;

	assign done = (step_q == ST_DONE);
	assign b    = head.data[bit_q];
	assign v    = ((32'd1 << pairs_q) - 32'd1) + accum_q;
	assign fmt  = (v > 32'd16) ? 5'd0 : v[4:0];
	assign row  = fmt_row(fmt);
	assign rp   = rate_pair(v[3:0]);
	assign ap   = aspect_pair(v[2:0]);

	// Grammar: one bit per cycle, only while the sequencer raises bit_go
	always_comb begin
		step_d   = step_q;
		pairs_d  = pairs_q;
		accum_d  = accum_q;
		half_d   = half_q;
		fields_d = fields_q;
		res      = RES_NONE;
		if (bit_go) begin
			unique case (step_q)
				ST_SIZE_F:   step_d = b ? ST_WIDTH : ST_CHROMA_F;
				ST_CHROMA_F: step_d = b ? ST_CHROMA : ST_SCAN_F;
				ST_SCAN_F:   step_d = b ? ST_INTERL : ST_RATE_F;
				ST_INTERL: begin
					fields_d[8] = {31'd0, b};
					step_d = b ? ST_TOPFF : ST_RATE_F;
				end
				ST_TOPFF: begin
					fields_d[9] = {31'd0, b};
					step_d = ST_RATE_F;
				end
				ST_RATE_F:   step_d = b ? ST_RATE_IX : ST_ASP_F;
				ST_ASP_F:    step_d = b ? ST_ASP_IX : ST_CLEAN_F;
				ST_CLEAN_F: begin
					if (b)
						step_d = ST_CLEAN_W;
					else
						res = RES_ALL;
				end
				ST_DONE: ;
				default: begin
					if (half_q) begin
						accum_d = {accum_q[30:0], b};
						half_d  = 1'b0;
					end else if (!b) begin
						if (pairs_q >= 6'(VALUE_BITS - 1)) begin
							res = RES_ERR;
						end else begin
							pairs_d = pairs_q + 6'd1;
							half_d  = 1'b1;
						end
					end else begin
						pairs_d = '0;
						accum_d = '0;
						case (step_q)
							ST_MAJOR, ST_MINOR, ST_PROFILE, ST_LEVEL: begin
								fields_d[step_q] = v;
								step_d = gstep_t'(step_q + 5'd1);
							end
							ST_FORMAT: begin
								fields_d[4]  = {27'd0, fmt};
								fields_d[5]  = row[0];
								fields_d[6]  = row[1];
								fields_d[8]  = row[2];
								fields_d[9]  = row[3];
								fields_d[10] = row[4];
								fields_d[11] = row[5];
								fields_d[12] = row[6];
								fields_d[13] = row[7];
								fields_d[14] = row[8];
								fields_d[15] = row[9];
								fields_d[16] = row[10];
								fields_d[17] = row[11];
								step_d = ST_SIZE_F;
							end
							ST_WIDTH:  begin fields_d[5] = v; step_d = ST_HEIGHT; end
							ST_HEIGHT: begin fields_d[6] = v; step_d = ST_CHROMA_F; end
							ST_CHROMA: begin fields_d[7] = v; step_d = ST_SCAN_F; end
							ST_RATE_IX: begin
								if (v == 32'd0) begin
									step_d = ST_RATE_N;
								end else begin
									if (v <= 32'd10) begin
										fields_d[10] = rp[63:32];
										fields_d[11] = rp[31:0];
									end
									step_d = ST_ASP_F;
								end
							end
							ST_RATE_N: begin fields_d[10] = v; step_d = ST_RATE_D; end
							ST_RATE_D: begin fields_d[11] = v; step_d = ST_ASP_F; end
							ST_ASP_IX: begin
								if (v == 32'd0) begin
									step_d = ST_ASP_N;
								end else begin
									if (v <= 32'd6) begin
										fields_d[12] = ap[63:32];
										fields_d[13] = ap[31:0];
									end
									step_d = ST_CLEAN_F;
								end
							end
							ST_ASP_N:   begin fields_d[12] = v; step_d = ST_ASP_D; end
							ST_ASP_D:   begin fields_d[13] = v; step_d = ST_CLEAN_F; end
							ST_CLEAN_W: begin fields_d[14] = v; step_d = ST_CLEAN_H; end
							ST_CLEAN_H: begin fields_d[15] = v; step_d = ST_CLEAN_L; end
							ST_CLEAN_L: begin fields_d[16] = v; step_d = ST_CLEAN_T; end
							ST_CLEAN_T: begin fields_d[17] = v; res = RES_ALL; end
							default: ;
						endcase
					end
				end
			endcase
			if (res != RES_NONE)
				step_d = ST_DONE;
		end
		// Rearm for a new unit
		if (rearm) begin
			step_d  = ST_MAJOR;
			pairs_d = '0;
			accum_d = '0;
			half_d  = 1'b0;
			for (int k = 0; k < NFIELDS; k++)
				fields_d[k] = '0;
		end
	end

	// Sequencer: byte walk, emission, error result and rearm
	always_comb begin
		state_d  = state_q;
		bit_d    = bit_q;
		idx_d    = idx_q;
		rearm_d  = rearm_q;
		bit_go   = 1'b0;
		deq      = 1'b0;
		rearm    = 1'b0;
		out_wr   = 1'b0;
		out_item = '0;
		unique case (state_q)
			C_RUN: begin
				if (head_valid) begin
					if (head.skip || done) begin
						deq = 1'b1;
						if (head.last && !done) begin
							state_d = C_ERR;
							rearm_d = 1'b1;
						end else if (head.last) begin
							rearm = 1'b1;
						end
					end else begin
						bit_go = 1'b1;
						if (res != RES_NONE || bit_q == 3'd0) begin
							deq     = 1'b1;
							bit_d   = 3'd7;
							rearm_d = head.last;
							idx_d   = '0;
							if (res == RES_ALL)
								state_d = C_EMIT;
							else if (res == RES_ERR || head.last)
								state_d = C_ERR;
						end else begin
							bit_d = bit_q - 3'd1;
						end
					end
				end
			end
			C_EMIT: begin
				out_wr = 1'b1;
				out_item.field_code  = idx_q;
				out_item.field_value = fields_q[idx_q];
				out_item.last_field  = (idx_q == 5'(NFIELDS - 1));
				if (!out_full) begin
					idx_d = idx_q + 5'd1;
					if (idx_q == 5'(NFIELDS - 1)) begin
						state_d = C_RUN;
						rearm   = rearm_q;
					end
				end
			end
			C_ERR: begin
				out_wr = 1'b1;
				out_item.last_field  = 1'b1;
				out_item.parse_error = 1'b1;
				if (!out_full) begin
					state_d = C_RUN;
					rearm   = rearm_q;
				end
			end
			default: state_d = C_RUN;
		endcase
	end

	// State registers; an error result without a pending rearm marks the decoder done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_RUN;
			step_q  <= ST_MAJOR;
			pairs_q <= '0;
			accum_q <= '0;
			half_q  <= 1'b0;
			bit_q   <= 3'd7;
			idx_q   <= '0;
			rearm_q <= 1'b0;
			for (int k = 0; k < NFIELDS; k++)
				fields_q[k] <= '0;
		end else begin
			state_q  <= state_d;
			step_q   <= (state_q == C_ERR && !out_full && !rearm_q) ? ST_DONE : step_d;
			pairs_q  <= pairs_d;
			accum_q  <= accum_d;
			half_q   <= half_d;
			bit_q    <= bit_d;
			idx_q    <= idx_d;
			rearm_q  <= rearm_d;
			fields_q <= fields_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_EMIT |-> idx_q < 5'(NFIELDS))
		else $error("emit index past field count");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr && out_item.parse_error |-> out_item.last_field)
		else $error("error result not marked last");
	a_err_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_ERR && !out_full |=> state_q == C_RUN)
		else $error("error result repeated");
	a_no_bits_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != C_RUN |-> !deq)
		else $error("byte consumed during emission");
`endif

endmodule

// ===== rtl/video_sequence_header_parser.sv =====
// Sequence header parser top level: front queue, bit-serial decoder, result queue.
// Prefix and post-header bytes are dropped whole; coded bytes go one bit per cycle
// through the code decoder when it is not emitting, which sets the throughput.
// A header gives 18 results, one per cycle unless core_full; an error gives one.
// arst_n clears all queues, decoder state and header fields asynchronously.
// Depends on vshp_pkg, vshp_front, vshp_core and vshp_outq.
module video_sequence_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        empty,
	input  logic        pop,
	output logic [4:0]  field_code,
	output logic [31:0] field_value,
	output logic        last_field,
	output logic        parse_error
);
	import vshp_pkg::*;

	fe_item_t head;
	logic     head_valid, deq;
	result_t  core_item, rd_item;
	logic     core_wr, core_full;

	vshp_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.data_byte(data_byte), .last_byte(last_byte),
		.deq(deq), .head_valid(head_valid), .head(head)
	);

	vshp_core u_core (
		.clk(clk), .arst_n(arst_n), .head_valid(head_valid), .head(head),
		.deq(deq), .out_wr(core_wr), .out_item(core_item), .out_full(core_full)
	);

	vshp_outq u_outq (
		.clk(clk), .arst_n(arst_n), .wr(core_wr), .wr_item(core_item),
		.wr_full(core_full), .pop(pop), .empty(empty), .rd_item(rd_item)
	);

	// Drive result ports from the queue head
	assign field_code  = rd_item.field_code;
	assign field_value = rd_item.field_value;
	assign last_field  = rd_item.last_field;
	assign parse_error = rd_item.parse_error;

endmodule
